// File: rtl/core/gamepad_report_to_midi_notes_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gamepad report to MIDI notes block
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_TO_MIDI_NOTES_MACROS_SVH
`define GAMEPAD_REPORT_TO_MIDI_NOTES_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define GPR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpr assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define GPR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpr assertion failed");

`endif

// File: rtl/core/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared constants, lane result type and note table.
// ----------------------------------------------------------------------------
package gpr_pkg;

  localparam int BtnCnt   = 12;
  localparam int PadCnt   = 4;
  localparam int LaneCnt  = BtnCnt + PadCnt;
  localparam int LaneIdxW = $clog2(LaneCnt);

  localparam logic [7:0] StatusNoteOn = 8'h90;
  localparam logic [6:0] VelPress     = 7'd127;
  localparam logic [6:0] VelRelease   = 7'd0;
  localparam logic [3:0] PadNone      = 4'h0;

  typedef enum logic {
    LaneButton = 1'b0,
    LanePad    = 1'b1
  } lane_kind_e;

  typedef struct packed {
    logic hit;
    logic press;
  } lane_res_t;

  function automatic logic [6:0] lane_note(input logic [LaneIdxW-1:0] idx);
    logic [6:0] note;
    case (idx)
      4'd0:    note = 7'd60;
      4'd1:    note = 7'd62;
      4'd2:    note = 7'd64;
      4'd3:    note = 7'd65;
      4'd4:    note = 7'd67;
      4'd5:    note = 7'd69;
      4'd6:    note = 7'd71;
      4'd7:    note = 7'd72;
      4'd8:    note = 7'd74;
      4'd9:    note = 7'd76;
      4'd10:   note = 7'd77;
      4'd11:   note = 7'd79;
      4'd12:   note = 7'd80;
      4'd13:   note = 7'd82;
      4'd14:   note = 7'd84;
      4'd15:   note = 7'd85;
      default: note = 7'd60;
    endcase
    return note;
  endfunction

endpackage

// File: rtl/core/gpr_lane.sv
// ----------------------------------------------------------------------------
// gpr_lane
// One change detector: a button lane or one direction of the pad.
// ----------------------------------------------------------------------------
module gpr_lane (
  input  gpr_pkg::lane_kind_e kind_i,
  input  logic [1:0]          pad_sel_i,
  input  logic                cur_i,
  input  logic                old_i,
  input  logic [3:0]          pad_i,
  input  logic                pad_chg_i,
  output gpr_pkg::lane_res_t  res_o
);
  import gpr_pkg::*;

  logic [3:0] dir_code;

  assign dir_code = 4'(4'b0001 << pad_sel_i);

  always_comb begin
    case (kind_i)
      LaneButton: begin
        res_o.hit   = cur_i ^ old_i;
        res_o.press = cur_i;
      end
      LanePad: begin
        res_o.hit   = pad_chg_i && ((pad_i == PadNone) || (pad_i == dir_code));
        res_o.press = (pad_i != PadNone);
      end
      default: begin
        res_o.hit   = 1'b0;
        res_o.press = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/gpr_merge.sv
// ----------------------------------------------------------------------------
// gpr_merge
// Collect lane hits; one note word per cycle unless stalled, lowest lane first.
// ----------------------------------------------------------------------------
module gpr_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  gpr_pkg::lane_res_t [gpr_pkg::LaneCnt-1:0] lanes_i,
  output logic                                busy_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [6:0]                          note_o,
  output logic [6:0]                          vel_o,
  output logic                                last_o
);
  import gpr_pkg::*;

  logic [LaneCnt-1:0]  pend_q, pend_d;
  logic [LaneCnt-1:0]  press_q;
  logic [LaneCnt-1:0]  rest;
  logic [LaneIdxW-1:0] sel;
  logic                found;
  logic                adv;
  logic                out_valid_q, out_valid_d;
  logic [6:0]          note_q, vel_q;
  logic                last_q;

  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int k = LaneCnt - 1; k >= 0; k--) begin
      if (pend_q[k]) begin
        sel   = LaneIdxW'(k);
        found = 1'b1;
      end
    end
  end

  assign rest = pend_q & ~(LaneCnt'(1) << sel);
  assign adv  = found && (!out_valid_q || !out_stall_i);

  always_comb begin
    pend_d = pend_q;
    if (load_i) begin
      for (int k = 0; k < LaneCnt; k++) pend_d[k] = lanes_i[k].hit;
    end else if (adv) begin
      pend_d = rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < LaneCnt; k++) press_q[k] <= lanes_i[k].press;
    end
    if (adv) begin
      note_q <= lane_note(sel);
      vel_q  <= press_q[sel] ? VelPress : VelRelease;
      last_q <= (rest == '0);
    end
  end

  assign busy_o      = (pend_q != '0);
  assign out_valid_o = out_valid_q;
  assign note_o      = note_q;
  assign vel_o       = vel_q;
  assign last_o      = last_q;

endmodule

// File: rtl/core/gamepad_report_to_midi_notes.sv
// ----------------------------------------------------------------------------
// gamepad_report_to_midi_notes
// Turn gamepad reports into MIDI note-on words.
// ----------------------------------------------------------------------------
// Input channel: one report word (bytes five and six) per accepted handshake.
// Output channel: one MIDI note word per handshake; status is always note on,
// channel 1, and last_of_run marks the final word caused by a report.
// Twelve button lanes and four pad lanes compare the report against stored
// state in the cycle the word is accepted; a merge stage then emits one word
// per cycle unless the receiver stalls, buttons first, then pad bits 0 to 3.
// The lane hits are registered in the merge queue, and each note word is then
// registered in the output register. A report causing words holds in_stall_o
// until its last word has left the merge queue, so no new report is taken
// meanwhile; the single-entry merge queue is the cause.
// Reset clears stored buttons and pad, and marks the pad as not yet seen, so
// the first report always counts as a pad change.
// When the receiver stalls, the output word holds and the merge stage waits;
// input stays stalled until the last word of the current report has entered
// the output register.
// ----------------------------------------------------------------------------
module gamepad_report_to_midi_notes (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] report_byte_five_i,
  input  logic [7:0] report_byte_six_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] status_byte_o,
  output logic [6:0] note_number_o,
  output logic [6:0] velocity_o,
  output logic       last_of_run_o
);
  import gpr_pkg::*;

  logic [BtnCnt-1:0]  btn_now;
  logic [3:0]         pad_now;
  logic [BtnCnt-1:0]  prev_btn_q;
  logic [3:0]         prev_pad_q;
  logic               pad_seen_q;
  logic               pad_chg;
  logic               in_acc;
  logic               busy;
  lane_res_t [LaneCnt-1:0] lanes;

  assign btn_now = BtnCnt'({report_byte_six_i, report_byte_five_i[7:4]});
  assign pad_now = report_byte_five_i[3:0];
  assign pad_chg = !pad_seen_q || (pad_now != prev_pad_q);
  assign in_acc  = in_valid_i && !in_stall_o;

  for (genvar g = 0; g < LaneCnt; g++) begin : g_lane
    if (g < BtnCnt) begin : g_btn
      gpr_lane u_lane (
        .kind_i    (LaneButton),
        .pad_sel_i (2'b00),
        .cur_i     (btn_now[g]),
        .old_i     (prev_btn_q[g]),
        .pad_i     (pad_now),
        .pad_chg_i (pad_chg),
        .res_o     (lanes[g])
      );
    end else begin : g_pad
      gpr_lane u_lane (
        .kind_i    (LanePad),
        .pad_sel_i (2'(g - BtnCnt)),
        .cur_i     (1'b0),
        .old_i     (1'b0),
        .pad_i     (pad_now),
        .pad_chg_i (pad_chg),
        .res_o     (lanes[g])
      );
    end
  end

  gpr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_acc),
    .lanes_i     (lanes),
    .busy_o      (busy),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .note_o      (note_number_o),
    .vel_o       (velocity_o),
    .last_o      (last_of_run_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_btn_q <= '0;
      prev_pad_q <= '0;
      pad_seen_q <= 1'b0;
    end else if (in_acc) begin
      prev_btn_q <= btn_now;
      prev_pad_q <= pad_now;
      pad_seen_q <= 1'b1;
    end
  end

  assign in_stall_o    = busy;
  assign status_byte_o = StatusNoteOn;

`include "gamepad_report_to_midi_notes_macros.svh"

  `GPR_ASSERT_NEXT(a_seen_after_accept, in_acc, pad_seen_q)
  `GPR_ASSERT_NEXT(a_run_continues, out_valid_o && !out_stall_i && !last_of_run_o, out_valid_o)
  `GPR_ASSERT_IMPL(a_idle_only_last, out_valid_o && !last_of_run_o, in_stall_o)

endmodule
